[hdl/pprf_pkg.sv]
// Shared types and constants of the pen report parameter filter.
package pprf_pkg;

	localparam int NUM_PEN_PARAMS = 3;
	localparam int VALUE_BITS = 8;
	localparam int TIME_BITS = 48;
	localparam int CFG_DATA_BITS = 48;
	localparam int CFG_INDEX_BITS = 2;

	// Event slots of one report: touch change, one query per parameter,
	// one value change per parameter.
	localparam int EVT_SLOTS = 1 + 2 * NUM_PEN_PARAMS;
	localparam int SLOT_BITS = $clog2(EVT_SLOTS);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_MATCH_ID = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FORCE_QUERY = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW = 2'd2;

	localparam logic [TIME_BITS-1:0] WINDOW_RESET = 48'd200000000;

	localparam logic [1:0] KIND_TOUCH = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_CHANGE = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	localparam int STYLE_IDX = 2;
	localparam logic [VALUE_BITS-1:0] STYLE_ALT_A = 8'h77;
	localparam logic [VALUE_BITS-1:0] STYLE_ALT_B = 8'hFF;
	localparam logic [VALUE_BITS-1:0] STYLE_MAPPED = 8'd6;

	typedef struct packed {
		logic [7:0] report_id;
		logic pen_near;
		logic touching;
		logic [VALUE_BITS-1:0] color_raw;
		logic [VALUE_BITS-1:0] width_raw;
		logic [VALUE_BITS-1:0] style_raw;
		logic [2:0] params_present;
		logic [TIME_BITS-1:0] time_ns;
	} rpt_word_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [1:0] event_data;
		logic [VALUE_BITS-1:0] color_out;
		logic [VALUE_BITS-1:0] width_out;
		logic [VALUE_BITS-1:0] style_out;
		logic drop_report;
		logic pass_through;
		logic last;
	} evt_word_t;

	// Classified report, handed from the front to the back.
	typedef struct packed {
		logic touch_ev;
		logic touch_val;
		logic query;
		logic [NUM_PEN_PARAMS-1:0] chg;
		logic [VALUE_BITS-1:0] color;
		logic [VALUE_BITS-1:0] width;
		logic [VALUE_BITS-1:0] style;
		logic drop;
		logic pass;
	} job_t;

endpackage

[hdl/pprf_front.sv]
// Front end: configuration, pen state and classification of each report.
module pprf_front import pprf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_INDEX_BITS-1:0] cfg_index,
	input logic [CFG_DATA_BITS-1:0] cfg_data,
	input rpt_word_t rpt,
	input logic rpt_valid,
	input logic full,
	output logic push,
	output job_t job
);

	logic [7:0] match_id_q;
	logic force_q;
	logic [TIME_BITS-1:0] window_q;
	logic prev_touch_q;
	logic start_valid_q;
	logic [TIME_BITS-1:0] start_time_q;
	logic [VALUE_BITS-1:0] cached_q [NUM_PEN_PARAMS];
	logic [VALUE_BITS-1:0] prev_raw_q [NUM_PEN_PARAMS];

	logic [VALUE_BITS-1:0] cached_d [NUM_PEN_PARAMS];
	logic [VALUE_BITS-1:0] prev_raw_d [NUM_PEN_PARAMS];
	logic [VALUE_BITS-1:0] raw [NUM_PEN_PARAMS];
	logic [VALUE_BITS-1:0] outv [NUM_PEN_PARAMS];
	logic [VALUE_BITS-1:0] v;
	logic [TIME_BITS-1:0] diff;
	logic match;
	logic t_eff;
	logic sv_after;
	logic arrival;
	logic in_win;

	assign push = rpt_valid && !full;

	always_comb begin
		match = rpt.report_id == match_id_q;
		t_eff = force_q ? rpt.pen_near : rpt.touching;
		// Lifting the pen clears the arrival mark before the range check.
		sv_after = t_eff & start_valid_q;
		arrival = !sv_after;
		diff = rpt.time_ns - start_time_q;
		in_win = !arrival && (rpt.time_ns > start_time_q) && (diff < window_q);
		raw[0] = rpt.color_raw;
		raw[1] = rpt.width_raw;
		raw[2] = rpt.style_raw;
		job = '0;
		v = '0;
		for (int i = 0; i < NUM_PEN_PARAMS; i++) begin
			cached_d[i] = cached_q[i];
			prev_raw_d[i] = prev_raw_q[i];
			outv[i] = raw[i];
		end
		if (!match) begin
			job.pass = 1'b1;
		end else begin
			job.touch_ev = t_eff != prev_touch_q;
			job.touch_val = t_eff;
			if (!rpt.pen_near) begin
				job.drop = 1'b1;
			end else begin
				job.query = arrival & force_q;
				for (int i = 0; i < NUM_PEN_PARAMS; i++) begin
					v = raw[i];
					if (i == STYLE_IDX && (v == STYLE_ALT_A || v == STYLE_ALT_B)) begin
						v = STYLE_MAPPED;
					end
					if (rpt.params_present[i]) begin
						if (prev_raw_q[i] != v) begin
							prev_raw_d[i] = v;
							if (in_win) begin
								job.chg[i] = cached_q[i] != v;
								cached_d[i] = v;
							end
						end
						outv[i] = cached_d[i];
					end
				end
			end
		end
		job.color = outv[0];
		job.width = outv[1];
		job.style = outv[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_id_q <= '0;
			force_q <= 1'b0;
			window_q <= WINDOW_RESET;
			prev_touch_q <= 1'b0;
			start_valid_q <= 1'b0;
			start_time_q <= '0;
			for (int i = 0; i < NUM_PEN_PARAMS; i++) begin
				cached_q[i] <= '0;
				prev_raw_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MATCH_ID: match_id_q <= cfg_data[7:0];
					REG_FORCE_QUERY: force_q <= cfg_data[0];
					REG_WINDOW: window_q <= cfg_data[TIME_BITS-1:0];
					default: ;
				endcase
			end
			if (push && match) begin
				prev_touch_q <= t_eff;
				if (!rpt.pen_near) begin
					start_valid_q <= sv_after;
				end else begin
					start_valid_q <= 1'b1;
					if (arrival) begin
						start_time_q <= rpt.time_ns;
					end
				end
				for (int i = 0; i < NUM_PEN_PARAMS; i++) begin
					cached_q[i] <= cached_d[i];
					prev_raw_q[i] <= prev_raw_d[i];
				end
			end
		end
	end

endmodule

[hdl/pprf_fifo.sv]
// Short queue of classified reports between the front and the back.
module pprf_fifo import pprf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input job_t wr_data,
	input logic pop,
	output job_t head,
	output logic full,
	output logic empty
);

	job_t mem [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0] count_q;

	assign full = count_q == FIFO_CNT_BITS'(FIFO_DEPTH);
	assign empty = count_q == '0;
	assign head = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

[hdl/pprf_back.sv]
// Back end: walks a queued report's events, one word a cycle if unstalled.
module pprf_back import pprf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input job_t head,
	input logic empty,
	output logic pop,
	output evt_word_t evt,
	output logic evt_valid,
	input logic evt_stall
);

	logic [EVT_SLOTS-1:0] sent_q;
	logic [EVT_SLOTS-1:0] pending;
	logic [SLOT_BITS-1:0] sel;
	logic hit;
	logic load;
	logic take;
	evt_word_t evt_q;
	evt_word_t nxt;
	logic valid_q;

	assign load = !valid_q || !evt_stall;
	assign take = load && !empty;
	assign pop = take && !hit;
	assign evt = evt_q;
	assign evt_valid = valid_q;

	always_comb begin
		pending[0] = head.touch_ev;
		for (int i = 0; i < NUM_PEN_PARAMS; i++) begin
			pending[1 + i] = head.query;
			pending[1 + NUM_PEN_PARAMS + i] = head.chg[i];
		end
		pending = pending & ~sent_q;
		hit = 1'b0;
		sel = '0;
		for (int s = 0; s < EVT_SLOTS; s++) begin
			if (!hit && pending[s]) begin
				hit = 1'b1;
				sel = SLOT_BITS'(s);
			end
		end
		nxt = '0;
		if (!hit) begin
			nxt.event_kind = KIND_DONE;
			nxt.color_out = head.color;
			nxt.width_out = head.width;
			nxt.style_out = head.style;
			nxt.drop_report = head.drop;
			nxt.pass_through = head.pass;
			nxt.last = 1'b1;
		end else if (sel == '0) begin
			nxt.event_kind = KIND_TOUCH;
			nxt.event_data = {1'b0, head.touch_val};
		end else if (sel <= SLOT_BITS'(NUM_PEN_PARAMS)) begin
			nxt.event_kind = KIND_QUERY;
			nxt.event_data = 2'(sel - SLOT_BITS'(1));
		end else begin
			nxt.event_kind = KIND_CHANGE;
			nxt.event_data = 2'(sel - SLOT_BITS'(NUM_PEN_PARAMS + 1));
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			evt_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sent_q <= '0;
		end else begin
			if (load) begin
				valid_q <= !empty;
			end
			if (take) begin
				if (hit) begin
					sent_q <= sent_q | (EVT_SLOTS'(1) << sel);
				end else begin
					sent_q <= '0;
				end
			end
		end
	end

endmodule

[hdl/pen_report_param_filter_core.sv]
// Top level of the pen report parameter filter.
// Reports enter on the rpt channel (rpt_valid, rpt_stall, rpt) and are
// accepted at an edge where rpt_valid is high and rpt_stall low. Results leave
// on the evt channel (evt_valid, evt_stall, evt), one word per edge where
// evt_valid is high and evt_stall low. Each report gives one to five words:
// a touch change, pen queries and parameter changes in that order, then a
// closing word with last set that carries the values for the report.
// The front classifies a report in the cycle it is accepted and updates the
// pen state at once, so a new report can be taken every cycle while the queue
// is not full. A four-entry queue decouples it from the back, which emits one
// word per cycle unless the receiver stalls; the first word of a report passes
// through the queue and the output register. Sustained throughput is thus one
// result word per cycle while the receiver does not stall, set by the single
// output register. rpt_stall rises only when the queue is full. When the
// receiver stalls, the output word holds and the queue fills behind it.
// Configuration must be written by the user through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block does not enforce this.
// Reset clears pen state, queue and output and loads the register defaults.
module pen_report_param_filter_core import pprf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_INDEX_BITS-1:0] cfg_index,
	input logic [CFG_DATA_BITS-1:0] cfg_data,
	input logic rpt_valid,
	output logic rpt_stall,
	input rpt_word_t rpt,
	output logic evt_valid,
	input logic evt_stall,
	output evt_word_t evt
);

	job_t job;
	job_t head;
	logic push;
	logic pop;
	logic full;
	logic empty;

	assign rpt_stall = full;

	pprf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.rpt(rpt),
		.rpt_valid(rpt_valid),
		.full(full),
		.push(push),
		.job(job)
	);

	pprf_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data(job),
		.pop(pop),
		.head(head),
		.full(full),
		.empty(empty)
	);

	pprf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.evt(evt),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall)
	);

	a_last_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> (evt.last == (evt.event_kind == KIND_DONE)))
		else $error("last flag does not match the closing word");

	a_event_no_values: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && evt.event_kind != KIND_DONE) |->
		(evt.color_out == '0 && evt.width_out == '0 && evt.style_out == '0 &&
		!evt.drop_report && !evt.pass_through))
		else $error("event word carries report values");

	a_no_word_from_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!evt_valid && empty) |=> !evt_valid)
		else $error("result word appeared with nothing queued");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue popped while empty");

endmodule

[tb/sv/pen_report_param_filter_core_test.sv]
// Self-checking testbench for the pen report parameter filter core.
`timescale 1ns / 1ps

module pen_report_param_filter_core_test;
	import pprf_pkg::*;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic rpt_valid = 1'b0;
	logic rpt_stall;
	rpt_word_t rpt = '0;
	logic evt_valid;
	logic evt_stall = 1'b0;
	evt_word_t evt;

	pen_report_param_filter_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.rpt_valid(rpt_valid),
		.rpt_stall(rpt_stall),
		.rpt(rpt),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt(evt)
	);

	// Register copies and pen state of the predictor.
	logic [7:0] match_id_cfg;
	logic force_query_cfg;
	logic [TIME_BITS-1:0] window_cfg;
	logic pen_touch_q;
	logic pen_start_valid;
	logic [TIME_BITS-1:0] pen_start_ns;
	logic [VALUE_BITS-1:0] cached_val [NUM_PEN_PARAMS];
	logic [VALUE_BITS-1:0] last_raw_val [NUM_PEN_PARAMS];

	rpt_word_t rpt_backlog [$];
	evt_word_t evt_due [$];
	evt_word_t want;

	int reports_queued = 0;
	int reports_accepted = 0;
	int words_checked = 0;
	int settings_used = 0;
	int err_count = 0;

	logic rpt_taken = 1'b0;
	logic rpt_in_flight = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	logic [31:0] cyc = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic evt_word_t evt_word(input logic [1:0] kind, input logic [1:0] data,
			input logic [7:0] c, input logic [7:0] w, input logic [7:0] s,
			input logic drop, input logic pass);
		evt_word_t e;
		e.event_kind = kind;
		e.event_data = data;
		e.color_out = c;
		e.width_out = w;
		e.style_out = s;
		e.drop_report = drop;
		e.pass_through = pass;
		e.last = (kind == KIND_DONE);
		return e;
	endfunction

	// Works out the result words of one accepted report and updates the pen state.
	task automatic predict_report(input rpt_word_t r);
		logic [VALUE_BITS-1:0] vals [NUM_PEN_PARAMS];
		logic [VALUE_BITS-1:0] v;
		logic touch_now;
		logic in_window;
		int i;
		vals[0] = r.color_raw;
		vals[1] = r.width_raw;
		vals[2] = r.style_raw;
		if (r.report_id != match_id_cfg) begin
			evt_due.push_back(evt_word(KIND_DONE, 2'd0, vals[0], vals[1], vals[2], 1'b0, 1'b1));
			return;
		end
		touch_now = force_query_cfg ? r.pen_near : r.touching;
		if (touch_now != pen_touch_q)
			evt_due.push_back(evt_word(KIND_TOUCH, {1'b0, touch_now}, 8'd0, 8'd0, 8'd0,
				1'b0, 1'b0));
		pen_touch_q = touch_now;
		if (!touch_now)
			pen_start_valid = 1'b0;
		if (!r.pen_near) begin
			evt_due.push_back(evt_word(KIND_DONE, 2'd0, vals[0], vals[1], vals[2], 1'b1, 1'b0));
			return;
		end
		if (!pen_start_valid) begin
			pen_start_valid = 1'b1;
			pen_start_ns = r.time_ns;
			if (force_query_cfg)
				for (i = 0; i < NUM_PEN_PARAMS; i++)
					evt_due.push_back(evt_word(KIND_QUERY, 2'(i), 8'd0, 8'd0, 8'd0,
						1'b0, 1'b0));
		end
		// The arrival report itself never falls inside the window.
		in_window = (r.time_ns > pen_start_ns) && ((r.time_ns - pen_start_ns) < window_cfg);
		for (i = 0; i < NUM_PEN_PARAMS; i++) begin
			if (r.params_present[i]) begin
				v = vals[i];
				if (i == STYLE_IDX && (v == STYLE_ALT_A || v == STYLE_ALT_B))
					v = STYLE_MAPPED;
				if (last_raw_val[i] != v) begin
					last_raw_val[i] = v;
					if (in_window) begin
						if (cached_val[i] != v)
							evt_due.push_back(evt_word(KIND_CHANGE, 2'(i), 8'd0, 8'd0,
								8'd0, 1'b0, 1'b0));
						cached_val[i] = v;
					end
				end
				vals[i] = cached_val[i];
			end
		end
		evt_due.push_back(evt_word(KIND_DONE, 2'd0, vals[0], vals[1], vals[2], 1'b0, 1'b0));
	endtask

	task automatic field_err(input string name, input logic [7:0] exp_v, input logic [7:0] got_v);
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
		err_count++;
	endtask

	// Sampling side: predicts on every accepted report and checks every accepted word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rpt_valid && !rpt_stall) begin
				predict_report(rpt);
				reports_accepted++;
				rpt_taken = 1'b1;
			end
			if (evt_valid && !evt_stall) begin
				words_checked++;
				if (evt_due.size() == 0) begin
					$display("%0t: unexpected word, expected none, got %h", $time, evt);
					err_count++;
				end else begin
					want = evt_due.pop_front();
					if (evt.event_kind !== want.event_kind)
						field_err("event_kind", 8'(want.event_kind), 8'(evt.event_kind));
					if (evt.event_data !== want.event_data)
						field_err("event_data", 8'(want.event_data), 8'(evt.event_data));
					if (evt.color_out !== want.color_out)
						field_err("color_out", want.color_out, evt.color_out);
					if (evt.width_out !== want.width_out)
						field_err("width_out", want.width_out, evt.width_out);
					if (evt.style_out !== want.style_out)
						field_err("style_out", want.style_out, evt.style_out);
					if (evt.drop_report !== want.drop_report)
						field_err("drop_report", 8'(want.drop_report),
							8'(evt.drop_report));
					if (evt.pass_through !== want.pass_through)
						field_err("pass_through", 8'(want.pass_through),
							8'(evt.pass_through));
					if (evt.last !== want.last)
						field_err("last", 8'(want.last), 8'(evt.last));
				end
			end
		end
	end

	// Driving side: reports go out in bursts; the receiver stalls on a slow pattern.
	always @(negedge clk) begin
		if (arst_n) begin
			cyc++;
			if (rpt_taken) begin
				rpt_taken = 1'b0;
				rpt_in_flight = 1'b0;
			end
			if (!rpt_in_flight) begin
				if (gap_left > 0 || rpt_backlog.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					rpt_valid <= 1'b0;
				end else begin
					rpt <= rpt_backlog.pop_front();
					rpt_valid <= 1'b1;
					rpt_in_flight = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
							: $urandom_range(0, 8);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
					end
				end
			end
			case (cyc[8:7])
				2'd0: evt_stall <= 1'b0;
				2'd1: evt_stall <= 1'($urandom_range(0, 1));
				2'd2: evt_stall <= (cyc[2:0] == 3'd0);
				default: evt_stall <= ($urandom_range(0, 7) < 6);
			endcase
		end
	end

	task automatic queue_report(input logic [7:0] id, input logic inr, input logic tch,
			input logic [7:0] c, input logic [7:0] w, input logic [7:0] s,
			input logic [2:0] pres, input logic [TIME_BITS-1:0] t);
		rpt_word_t r;
		r.report_id = id;
		r.pen_near = inr;
		r.touching = tch;
		r.color_raw = c;
		r.width_raw = w;
		r.style_raw = s;
		r.params_present = pres;
		r.time_ns = t;
		rpt_backlog.push_back(r);
		reports_queued++;
	endtask

	task automatic wait_drained();
		while (reports_accepted != reports_queued || evt_due.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_MATCH_ID: match_id_cfg = val[7:0];
			REG_FORCE_QUERY: force_query_cfg = val[0];
			REG_WINDOW: window_cfg = val[TIME_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_setting(input logic [7:0] id, input logic fq,
			input logic [TIME_BITS-1:0] win);
		write_reg(REG_MATCH_ID, CFG_DATA_BITS'(id));
		write_reg(REG_FORCE_QUERY, CFG_DATA_BITS'(fq));
		write_reg(REG_WINDOW, win);
		settings_used++;
	endtask

	function automatic logic [7:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return STYLE_ALT_A;
			3: return 8'($urandom_range(0, 7));
			default: return 8'($urandom);
		endcase
	endfunction

	// Pen strokes: arrival, a run of reports with advancing time and changing
	// parameters, then a lift. Some reports carry a foreign id or leave range.
	task automatic gen_strokes(input int n_items, input int unsigned step);
		int left;
		int len;
		int k;
		logic [TIME_BITS-1:0] now;
		logic [7:0] c, w, s, id;
		logic [2:0] pres;
		left = n_items;
		now = TIME_BITS'({$urandom, $urandom});
		c = pick_value();
		w = pick_value();
		s = pick_value();
		while (left > 0) begin
			len = $urandom_range(2, 12);
			if ($urandom_range(0, 4) == 0)
				now = TIME_BITS'({$urandom, $urandom});
			for (k = 0; k < len && left > 0; k++) begin
				id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : match_id_cfg;
				if ($urandom_range(0, 2) == 0) c = pick_value();
				if ($urandom_range(0, 2) == 0) w = pick_value();
				if ($urandom_range(0, 2) == 0) s = pick_value();
				pres = ($urandom_range(0, 2) == 0) ? 3'($urandom) : 3'b111;
				if ($urandom_range(0, 5) != 0)
					now = now + TIME_BITS'($urandom_range(0, step));
				queue_report(id, $urandom_range(0, 7) != 0,
					(k != len - 1) && ($urandom_range(0, 9) != 0), c, w, s, pres, now);
				if (id == match_id_cfg)
					left--;
			end
		end
	endtask

	initial begin
		match_id_cfg = 8'd0;
		force_query_cfg = 1'b0;
		window_cfg = WINDOW_RESET;
		pen_touch_q = 1'b0;
		pen_start_valid = 1'b0;
		pen_start_ns = '0;
		for (int i = 0; i < NUM_PEN_PARAMS; i++) begin
			cached_val[i] = '0;
			last_raw_val[i] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		settings_used = 1;

		// Register defaults: foreign id, arrival, changes at both window edges,
		// style aliases, absent parameters, leaving range and lifting.
		queue_report(8'hFF, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 3'b111, 48'hFFFF_FFFF_FFFF);
		queue_report(8'h00, 1'b1, 1'b1, 8'd1, 8'd2, 8'd3, 3'b111, 48'd1000);
		queue_report(8'h00, 1'b1, 1'b1, 8'hFF, 8'h80, STYLE_ALT_A, 3'b111, 48'd2000);
		queue_report(8'h00, 1'b1, 1'b1, 8'hFF, 8'h80, STYLE_ALT_B, 3'b111, 48'd3000);
		queue_report(8'h00, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 3'b000, 48'd4000);
		queue_report(8'h00, 1'b1, 1'b1, 8'h10, 8'h20, 8'h30, 3'b111, 48'd200001000);
		queue_report(8'h00, 1'b1, 1'b1, 8'h11, 8'h21, 8'h31, 3'b111, 48'd200000999);
		queue_report(8'h00, 1'b1, 1'b1, 8'h12, 8'h22, 8'h32, 3'b101, 48'd500);
		queue_report(8'h00, 1'b0, 1'b1, 8'h40, 8'h41, 8'h42, 3'b111, 48'd5000);
		queue_report(8'h00, 1'b0, 1'b0, 8'h43, 8'h44, 8'h45, 3'b111, 48'd5100);
		queue_report(8'h00, 1'b1, 1'b0, 8'h46, 8'h47, 8'h48, 3'b010, 48'd6000);
		wait_drained();

		// A write to the spare index must leave every register alone.
		write_reg(REG_SPARE, '1);
		load_setting(8'hA5, 1'b1, 48'hFFFF_FFFF_FFFF);
		queue_report(8'hA5, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 3'b111, 48'd0);
		queue_report(8'hA5, 1'b1, 1'b0, 8'h05, 8'h06, 8'h07, 3'b111, 48'd1);
		queue_report(8'hA5, 1'b0, 1'b1, 8'h08, 8'h09, 8'h0A, 3'b111, 48'd2);
		queue_report(8'hA5, 1'b1, 1'b1, 8'hFE, 8'h01, 8'hFF, 3'b111, 48'hFFFF_FFFF_FFFF);
		queue_report(8'h5A, 1'b1, 1'b1, 8'h00, 8'hFF, 8'h00, 3'b111, 48'd3);
		wait_drained();

		load_setting(8'hA5, 1'b0, 48'd0);
		queue_report(8'hA5, 1'b1, 1'b1, 8'h21, 8'h22, 8'h23, 3'b111, 48'd100);
		queue_report(8'hA5, 1'b1, 1'b1, 8'h31, 8'h32, 8'h33, 3'b111, 48'd200);
		wait_drained();

		load_setting(8'h00, 1'b0, 48'd5000);
		gen_strokes(75, 2000);
		wait_drained();
		load_setting(8'hA5, 1'b1, 48'hFFFF_FFFF_FFFF);
		gen_strokes(75, 1 << 20);
		wait_drained();
		load_setting(8'hFF, 1'b0, 48'd0);
		gen_strokes(75, 1000);
		wait_drained();
		load_setting(8'($urandom), 1'b1, 48'd20000);
		gen_strokes(75, 9000);
		wait_drained();
		load_setting(8'h3C, 1'b0, WINDOW_RESET);
		gen_strokes(75, 60000000);
		wait_drained();
		repeat (16) @(negedge clk);

		$display("Run covered %0d reports and %0d result words over %0d register settings.",
			reports_accepted, words_checked, settings_used);
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timed out with %0d words outstanding.", evt_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
